FILE: sv/mab_pkg.sv
package mab_pkg;

  localparam int unsigned MAX_ORDER_DEF = 8;
  localparam int unsigned IDX_W         = 3;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned SIZE_W        = 4;
  localparam logic [SIZE_W-1:0] SIZE_RST = 4'd8;

  // request command codes
  typedef enum logic [1:0] {
    CMD_WR_A    = 2'd0,
    CMD_WR_B    = 2'd1,
    CMD_COMPUTE = 2'd2
  } cmd_e;

  // which sum a MAC step belongs to
  typedef enum logic [1:0] {
    OP_AB = 2'd0,  // P[i][j] += A[i][k]*B[k][j]
    OP_T1 = 2'd1,  // t1 += P[i][k]*B[j][k]
    OP_T2 = 2'd2   // t2 += A[k][i]*A[k][j]
  } op_e;

  typedef struct packed {
    logic             valid;
    op_e              op;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
    logic             first;  // restart the accumulator
    logic             last;   // closes the current sum
    logic             tail;   // last element of R
  } mac_cmd_t;

  typedef struct packed {
    logic busy;         // a step is somewhere in the pipe
    logic res_pending;  // output register holds a result
  } dp_status_t;

  typedef struct packed {
    logic                     we_a;
    logic                     we_b;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] data;
  } load_t;

  // clamp a 50-bit signed sum to the 32-bit range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [49:0] v);
    logic fits;
    fits = (v[49:31] == {19{1'b0}}) || (v[49:31] == {19{1'b1}});
    if (fits) begin
      return v[31:0];
    end else if (v[49]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7FFF_FFFF;
    end
  endfunction

endpackage

FILE: sv/mab_in_if.sv
interface mab_in_if;
  import mab_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic [IDX_W-1:0]         row;
  logic [IDX_W-1:0]         col;
  logic signed [DATA_W-1:0] element;

  modport source (output valid, output cmd, output row, output col, output element,
                  input ready);
  modport sink   (input valid, input cmd, input row, input col, input element,
                  output ready);
endinterface

FILE: sv/mab_out_if.sv
interface mab_out_if;
  import mab_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic signed [DATA_W-1:0] value;
  logic                     last;

  modport source (output valid, output out_row, output out_col, output value,
                  output last, input ready);
  modport sink   (input valid, input out_row, input out_col, input value,
                  input last, output ready);
endinterface

FILE: sv/mab_datapath.sv
module mab_datapath #(
  parameter int unsigned MAX_ORDER = mab_pkg::MAX_ORDER_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mab_pkg::load_t       load_i,
  input  mab_pkg::mac_cmd_t    cmd_i,
  output mab_pkg::dp_status_t  sts_o,
  mab_out_if.source            out_o
);
  import mab_pkg::*;

  localparam int unsigned DEPTH  = MAX_ORDER * MAX_ORDER;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  function automatic logic [ADDR_W-1:0] addr(input logic [IDX_W-1:0] r,
                                             input logic [IDX_W-1:0] c);
    return ADDR_W'(r * MAX_ORDER + c);
  endfunction

  logic signed [DATA_W-1:0] mem_a [DEPTH];
  logic signed [DATA_W-1:0] mem_b [DEPTH];
  logic signed [DATA_W-1:0] mem_p [DEPTH];

  logic [ADDR_W-1:0] ra0, ra1, rb, rp, wp;
  logic signed [DATA_W-1:0] rd_a0_q, rd_a1_q, rd_b_q, rd_p_q;

  mac_cmd_t s1_q, s2_q;
  logic signed [DATA_W-1:0] x, y;
  logic signed [63:0]       full;
  logic signed [47:0]       prod_q;
  logic signed [DATA_W-1:0] acc_q, base, sum_sat;
  logic signed [DATA_W-1:0] t1_q, t2_q;
  logic                     p_we;

  logic                     fin_valid_q;
  logic [IDX_W-1:0]         fin_i_q, fin_j_q;
  logic                     fin_tail_q;

  logic                     out_valid_q;
  logic [IDX_W-1:0]         out_row_q, out_col_q;
  logic signed [DATA_W-1:0] out_value_q;
  logic                     out_last_q;

  // read addresses for the step in stage 0
  always_comb begin
    ra0 = (cmd_i.op == OP_AB) ? addr(cmd_i.i, cmd_i.k) : addr(cmd_i.k, cmd_i.i);
    ra1 = addr(cmd_i.k, cmd_i.j);
    rb  = (cmd_i.op == OP_AB) ? addr(cmd_i.k, cmd_i.j) : addr(cmd_i.j, cmd_i.k);
    rp  = addr(cmd_i.i, cmd_i.k);
    wp  = addr(s2_q.i, s2_q.j);
  end

  always_ff @(posedge clk_i) begin
    if (load_i.we_a) begin
      mem_a[addr(load_i.row, load_i.col)] <= load_i.data;
    end
    rd_a0_q <= mem_a[ra0];
    rd_a1_q <= mem_a[ra1];
  end

  always_ff @(posedge clk_i) begin
    if (load_i.we_b) begin
      mem_b[addr(load_i.row, load_i.col)] <= load_i.data;
    end
    rd_b_q <= mem_b[rb];
  end

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      mem_p[wp] <= sum_sat;
    end
    rd_p_q <= mem_p[rp];
  end

  // stage 1: operand select and multiply, truncated to Q16.16 (floor)
  always_comb begin
    x    = (s1_q.op == OP_T1) ? rd_p_q : rd_a0_q;
    y    = (s1_q.op == OP_T2) ? rd_a1_q : rd_b_q;
    full = x * y;
  end

  // stage 2: saturating accumulate
  always_comb begin
    base    = s2_q.first ? '0 : acc_q;
    sum_sat = sat32({{18{base[31]}}, base} + {{2{prod_q[47]}}, prod_q});
    p_we    = s2_q.valid && s2_q.last && (s2_q.op == OP_AB);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= '0;
      s2_q        <= '0;
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_q        <= cmd_i;
      s2_q        <= s1_q;
      fin_valid_q <= s2_q.valid && s2_q.last && (s2_q.op == OP_T2);
      if (fin_valid_q) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= full[63:16];
    if (s2_q.valid) begin
      acc_q <= sum_sat;
    end
    if (s2_q.valid && s2_q.last && (s2_q.op == OP_T1)) begin
      t1_q <= sum_sat;
    end
    if (s2_q.valid && s2_q.last && (s2_q.op == OP_T2)) begin
      t2_q       <= sum_sat;
      fin_i_q    <= s2_q.i;
      fin_j_q    <= s2_q.j;
      fin_tail_q <= s2_q.tail;
    end
    if (fin_valid_q) begin
      out_row_q   <= fin_i_q;
      out_col_q   <= fin_j_q;
      out_value_q <= sat32({{18{t1_q[31]}}, t1_q} + {{18{t2_q[31]}}, t2_q});
      out_last_q  <= fin_tail_q;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.out_row = out_row_q;
  assign out_o.out_col = out_col_q;
  assign out_o.value   = out_value_q;
  assign out_o.last    = out_last_q;

  assign sts_o.busy        = cmd_i.valid || s1_q.valid || s2_q.valid || fin_valid_q;
  assign sts_o.res_pending = out_valid_q;

  a_fin_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_valid_q |-> !out_valid_q)
    else $error("finished element while output register is occupied");

  a_p_no_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(p_we && cmd_i.valid && (cmd_i.op == OP_T1)))
    else $error("P read while A*B pass still writing");

endmodule

FILE: sv/mab_ctrl.sv
module mab_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [mab_pkg::IDX_W-1:0]    last_idx_i,
  input  mab_pkg::dp_status_t          sts_i,
  output logic                         idle_o,
  output mab_pkg::mac_cmd_t            cmd_o
);
  import mab_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AB_RUN,
    ST_AB_DRAIN,
    ST_EL_WAIT,
    ST_T1_RUN,
    ST_T2_RUN,
    ST_END_DRAIN
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  mac_cmd_t         cmd_q, cmd_d;

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    cmd_d   = '0;
    cmd_d.i = i_q;
    cmd_d.j = j_q;
    cmd_d.k = k_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
          state_d = ST_AB_RUN;
        end
      end
      ST_AB_RUN: begin
        cmd_d.valid = 1'b1;
        cmd_d.op    = OP_AB;
        cmd_d.first = (k_q == '0);
        cmd_d.last  = (k_q == last_idx_i);
        if (k_q == last_idx_i) begin
          k_d = '0;
          if (j_q == last_idx_i) begin
            j_d = '0;
            if (i_q == last_idx_i) begin
              i_d     = '0;
              state_d = ST_AB_DRAIN;
            end else begin
              i_d = IDX_W'(i_q + 1'b1);
            end
          end else begin
            j_d = IDX_W'(j_q + 1'b1);
          end
        end else begin
          k_d = IDX_W'(k_q + 1'b1);
        end
      end
      ST_AB_DRAIN: begin
        if (!sts_i.busy) begin
          state_d = ST_EL_WAIT;
        end
      end
      ST_EL_WAIT: begin
        if (!sts_i.busy && !sts_i.res_pending) begin
          k_d     = '0;
          state_d = ST_T1_RUN;
        end
      end
      ST_T1_RUN: begin
        cmd_d.valid = 1'b1;
        cmd_d.op    = OP_T1;
        cmd_d.first = (k_q == '0);
        cmd_d.last  = (k_q == last_idx_i);
        if (k_q == last_idx_i) begin
          k_d     = '0;
          state_d = ST_T2_RUN;
        end else begin
          k_d = IDX_W'(k_q + 1'b1);
        end
      end
      ST_T2_RUN: begin
        cmd_d.valid = 1'b1;
        cmd_d.op    = OP_T2;
        cmd_d.first = (k_q == '0);
        cmd_d.last  = (k_q == i_q);
        cmd_d.tail  = (i_q == last_idx_i) && (j_q == last_idx_i);
        if (k_q == i_q) begin
          k_d     = '0;
          state_d = ST_EL_WAIT;
          if (j_q == last_idx_i) begin
            j_d = '0;
            if (i_q == last_idx_i) begin
              i_d     = '0;
              state_d = ST_END_DRAIN;
            end else begin
              i_d = IDX_W'(i_q + 1'b1);
            end
          end else begin
            j_d = IDX_W'(j_q + 1'b1);
          end
        end else begin
          k_d = IDX_W'(k_q + 1'b1);
        end
      end
      ST_END_DRAIN: begin
        if (!sts_i.busy) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      cmd_q   <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      cmd_q   <= cmd_d;
    end
  end

  assign idle_o = (state_q == ST_IDLE);
  assign cmd_o  = cmd_q;

  a_t2_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_q.valid && (cmd_q.op == OP_T2)) |-> (cmd_q.k <= cmd_q.i))
    else $error("upper-triangle step beyond the diagonal");

  a_tail_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_q.valid && cmd_q.tail && cmd_q.last) |-> (state_q == ST_END_DRAIN))
    else $error("final element issued but sequencer not finishing");

endmodule

FILE: sv/matrix_abbt_plus_ata.sv
// Matrix engine computing R = A*B*B^T + U^T*A on the leading N x N block, where
// U is the upper triangle of A (diagonal included) and N is matrix_size clamped
// to 1..MAX_ORDER. Requests arrive on in_i: cmd 0 writes A[row][col], cmd 1 writes
// B[row][col], cmd 2 computes and streams R on out_o in row-major order with last
// set on the final element; cmd 3 is dropped. All values are signed Q16.16: each
// product is truncated toward minus infinity, every running sum saturates, and
// the two sums of an element saturate once more when added. A compute request
// runs on a single 32x32 multiply-accumulate pipe fed by the three element
// memories: first the A*B pass into the partial store, then for each result
// element the two sums at one MAC step per cycle, then pipe drain and the
// output handoff; a consumer stall holds the next element back. No new
// request is taken until the last result has left the pipe; the final result
// may still sit in the output register when the next request is accepted.
// Elements of A and B must be written before a compute request uses them.
// matrix_size is written on cfg_we_i and resets to 8; the user must write it
// only while the block is idle, which the block itself does not enforce.
module matrix_abbt_plus_ata #(
  parameter int unsigned MAX_ORDER = mab_pkg::MAX_ORDER_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  mab_in_if.sink                     in_i,
  mab_out_if.source                  out_o,
  input  logic                       cfg_we_i,
  input  logic [mab_pkg::SIZE_W-1:0] cfg_data_i
);
  import mab_pkg::*;

  logic [SIZE_W-1:0] size_q;
  logic [SIZE_W-1:0] order;
  logic [IDX_W-1:0]  last_idx;
  logic              idle;
  logic              accept;
  logic              in_range;
  logic              start;
  load_t             load;
  mac_cmd_t          mac_cmd;
  dp_status_t        dp_sts;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RST;
    end else if (cfg_we_i) begin
      size_q <= cfg_data_i;
    end
  end

  // effective order: zero acts as one, oversize acts as MAX_ORDER
  always_comb begin
    if (size_q == '0) begin
      order = SIZE_W'(1);
    end else if (32'(size_q) > MAX_ORDER) begin
      order = SIZE_W'(MAX_ORDER);
    end else begin
      order = size_q;
    end
    last_idx = IDX_W'(order - 1'b1);
  end

  assign in_i.ready = idle;
  assign accept     = in_i.valid && idle;
  // writes outside the stored array are dropped
  assign in_range   = (32'(in_i.row) < MAX_ORDER) && (32'(in_i.col) < MAX_ORDER);

  always_comb begin
    load.we_a = 1'b0;
    load.we_b = 1'b0;
    load.row  = in_i.row;
    load.col  = in_i.col;
    load.data = in_i.element;
    start     = 1'b0;
    unique case (cmd_e'(in_i.cmd))
      CMD_WR_A:    load.we_a = accept && in_range;
      CMD_WR_B:    load.we_b = accept && in_range;
      CMD_COMPUTE: start     = accept;
      default:     start     = 1'b0;
    endcase
  end

  mab_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .last_idx_i (last_idx),
    .sts_i      (dp_sts),
    .idle_o     (idle),
    .cmd_o      (mac_cmd)
  );

  mab_datapath #(
    .MAX_ORDER (MAX_ORDER)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .cmd_i  (mac_cmd),
    .sts_o  (dp_sts),
    .out_o  (out_o)
  );

endmodule

FILE: dv/abbt_checker.sv
`timescale 1ns / 1ps
module abbt_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  mab_in_if                          in_m,
  mab_out_if                         out_m,
  input  logic                       cfg_we_i,
  input  logic [mab_pkg::SIZE_W-1:0] cfg_data_i,
  output int                         fail_count_o,
  output int                         owed_o
);
  import mab_pkg::*;

  localparam int unsigned ORD = MAX_ORDER_DEF;
  localparam longint Q_MAX = 2147483647;
  localparam longint Q_MIN = -Q_MAX - 1;

  typedef logic signed [DATA_W-1:0] q16_t;

  typedef struct {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    q16_t             value;
    logic             last;
  } r_elem_t;

  q16_t              mat_a   [ORD*ORD];
  q16_t              mat_b   [ORD*ORD];
  q16_t              prod_ab [ORD*ORD];
  logic [SIZE_W-1:0] size_r;
  r_elem_t           r_due[$];

  function automatic longint clip32(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // exact product, low 16 bits dropped (floor)
  function automatic longint qmul(q16_t x, q16_t y);
    longint p;
    p = longint'(x) * longint'(y);
    return p >>> 16;
  endfunction

  // P = A*B, then R = P*B^T + U^T*A, queued in row-major order
  function automatic void form_r();
    int unsigned n;
    longint      acc;
    longint      t1;
    longint      t2;
    r_elem_t     e;
    n = (size_r == 0) ? 1 : ((size_r > ORD) ? ORD : size_r);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = 0;
        for (int k = 0; k < n; k++) begin
          acc = clip32(acc + qmul(mat_a[i*ORD+k], mat_b[k*ORD+j]));
        end
        prod_ab[i*ORD+j] = q16_t'(acc);
      end
    end
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        t1 = 0;
        t2 = 0;
        for (int k = 0; k < n; k++) begin
          t1 = clip32(t1 + qmul(prod_ab[i*ORD+k], mat_b[j*ORD+k]));
        end
        for (int k = 0; k <= i; k++) begin
          t2 = clip32(t2 + qmul(mat_a[k*ORD+i], mat_a[k*ORD+j]));
        end
        e.row   = IDX_W'(i);
        e.col   = IDX_W'(j);
        e.value = q16_t'(clip32(t1 + t2));
        e.last  = (i == n - 1) && (j == n - 1);
        r_due.push_back(e);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    r_elem_t want;
    int      errs;
    if (!rst_ni) begin
      size_r = SIZE_RST;
      r_due.delete();
      owed_o       <= 0;
      fail_count_o <= 0;
    end else begin
      errs = 0;
      if (out_m.valid && out_m.ready) begin
        if (r_due.size() == 0) begin
          $error("unexpected result (%0d,%0d) value %0d last %0d",
                 out_m.out_row, out_m.out_col, out_m.value, out_m.last);
          errs++;
        end else begin
          want = r_due.pop_front();
          if (out_m.out_row !== want.row) begin
            $error("out_row: expected %0d, got %0d", want.row, out_m.out_row);
            errs++;
          end
          if (out_m.out_col !== want.col) begin
            $error("out_col: expected %0d, got %0d", want.col, out_m.out_col);
            errs++;
          end
          if (out_m.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, out_m.value);
            errs++;
          end
          if (out_m.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_m.last);
            errs++;
          end
        end
      end
      if (in_m.valid && in_m.ready) begin
        case (in_m.cmd)
          CMD_WR_A:    mat_a[in_m.row*ORD+in_m.col] = in_m.element;
          CMD_WR_B:    mat_b[in_m.row*ORD+in_m.col] = in_m.element;
          CMD_COMPUTE: form_r();
          default:     ;
        endcase
      end
      if (cfg_we_i) begin
        size_r = cfg_data_i;
      end
      fail_count_o <= fail_count_o + errs;
      owed_o       <= r_due.size();
    end
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the A*B*B^T + U^T*A engine. Prediction and
// comparison live in abbt_checker, which sits beside the DUT on the same
// channels and hands back a failure count and the number of R elements
// still owed.
module tb_top;
  import mab_pkg::*;

  localparam int unsigned ORD        = MAX_ORDER_DEF;
  localparam int unsigned RAND_REQS  = 380;
  localparam int unsigned HOLD_OFF   = 500;  // one long consumer stall
  localparam logic [1:0]  CMD_UNUSED = 2'd3;

  typedef logic signed [DATA_W-1:0] q16_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_data;
  int                fail_count;
  int                owed;

  // stimulus-side bookkeeping: which elements hold a value, current order
  bit          a_set [ORD*ORD];
  bit          b_set [ORD*ORD];
  int unsigned cur_n;
  int unsigned reqs_sent;
  int unsigned gap_calm;

  mab_in_if  req_if ();
  mab_out_if res_if ();

  matrix_abbt_plus_ata dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (req_if),
    .out_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  abbt_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_m         (req_if),
    .out_m        (res_if),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .owed_o       (owed)
  );

  always #4 clk_i = ~clk_i;

  // Hard stop at about 4x the worst case, which is every request a full 8x8
  // compute with every result waiting out the longest stall.
  initial begin
    #(80_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Mostly short gaps, a few long ones, and calm runs with none at all.
  function automatic int unsigned pick_gap();
    int unsigned pick;
    if (gap_calm > 0) begin
      gap_calm--;
      return 0;
    end
    pick = $urandom_range(99);
    if (pick < 4) gap_calm = $urandom_range(20, 60);
    if (pick < 45) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Element values: corner values, small and medium Q16.16, full range.
  function automatic q16_t rand_q();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      case ($urandom_range(5))
        0:       return 32'sh7FFF_FFFF;
        1:       return 32'sh8000_0000;
        2:       return '0;
        3:       return -1;
        4:       return 32'sh0001_0000;
        default: return -32'sh0001_0000;
      endcase
    end
    if (pick < 45) return q16_t'($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
    if (pick < 75) return q16_t'($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
    return q16_t'($urandom());
  endfunction

  // Offer one request and hold it until the DUT takes it. valid stays high
  // into the next request when no gap follows.
  task automatic send(logic [1:0] c, int unsigned r, int unsigned k, q16_t e);
    int unsigned gap;
    req_if.valid   <= 1'b1;
    req_if.cmd     <= c;
    req_if.row     <= r[IDX_W-1:0];
    req_if.col     <= k[IDX_W-1:0];
    req_if.element <= e;
    do @(posedge clk_i); while (!req_if.ready);
    if (c == CMD_WR_A) a_set[r*ORD+k] = 1'b1;
    if (c == CMD_WR_B) b_set[r*ORD+k] = 1'b1;
    if (c != CMD_UNUSED) reqs_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait for every owed R element to come out.
  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (owed != 0);
  endtask

  // matrix_size only changes while the engine is idle. Writes leave no
  // result behind, so a short settle after the drain covers them.
  task automatic set_order(int unsigned v);
    drain();
    repeat (40) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= SIZE_W'(v);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    cur_n = (v == 0) ? 1 : ((v > ORD) ? ORD : v);
  endtask

  // Every element a compute reads must have been written first.
  task automatic fill_block();
    for (int r = 0; r < cur_n; r++) begin
      for (int k = 0; k < cur_n; k++) begin
        if (!a_set[r*ORD+k]) send(CMD_WR_A, r, k, rand_q());
        if (!b_set[r*ORD+k]) send(CMD_WR_B, r, k, rand_q());
      end
    end
  endtask

  task automatic compute();
    send(CMD_COMPUTE, $urandom_range(7), $urandom_range(7), q16_t'($urandom()));
  endtask

  // Consumer: random stalls plus one long hold-off while the producer keeps
  // offering, so the pipe backs up into the request channel.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned run_left;
    int unsigned pick;
    bit          held_off;
    stall_left = 0;
    run_left   = 0;
    held_off   = 1'b0;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!held_off && owed >= 4 && req_if.valid) begin
        held_off   = 1'b1;
        stall_left = HOLD_OFF;
      end
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          pick = $urandom_range(99);
          if (pick < 5) run_left = $urandom_range(30, 100);
          else if (pick < 55) stall_left = 0;
          else if (pick < 85) stall_left = $urandom_range(1, 3);
          else if (pick < 97) stall_left = $urandom_range(4, 12);
          else stall_left = $urandom_range(20, 60);
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned n_wr;
    int unsigned lim;
    rst_ni         <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_data       <= SIZE_RST;
    req_if.valid   <= 1'b0;
    req_if.cmd     <= CMD_WR_A;
    req_if.row     <= '0;
    req_if.col     <= '0;
    req_if.element <= '0;
    cur_n     = ORD;
    reqs_sent = 0;
    gap_calm  = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed ---
    // 1x1: positive saturation, then MIN*MIN (product overflows to max)
    set_order(1);
    send(CMD_WR_A, 0, 0, 32'sh7FFF_FFFF);
    send(CMD_WR_B, 0, 0, 32'sh7FFF_FFFF);
    compute();
    send(CMD_WR_A, 0, 0, 32'sh8000_0000);
    send(CMD_WR_B, 0, 0, 32'sh8000_0000);
    compute();
    // tiny negative product truncates toward minus infinity
    send(CMD_WR_A, 0, 0, -1);
    send(CMD_WR_B, 0, 0, 32'sh0000_0001);
    compute();
    // unused command is dropped
    send(CMD_UNUSED, 7, 7, 32'sh7FFF_FFFF);
    // writes outside the active block are stored but unused
    send(CMD_WR_A, 7, 7, 32'sh8000_0000);
    send(CMD_WR_B, 7, 0, 32'sh1234_5678);
    compute();
    // order 0 behaves as 1
    set_order(0);
    compute();
    // 2x2 with mixed signs: exercises the upper-triangle term
    set_order(2);
    send(CMD_WR_A, 0, 0, 32'sh0002_0000);
    send(CMD_WR_A, 0, 1, -32'sh0001_8000);
    send(CMD_WR_A, 1, 0, 32'sh0003_0000);
    send(CMD_WR_A, 1, 1, -32'sh0000_4000);
    send(CMD_WR_B, 0, 0, -32'sh0001_0000);
    send(CMD_WR_B, 0, 1, 32'sh0000_8000);
    send(CMD_WR_B, 1, 0, 32'sh0004_0000);
    send(CMD_WR_B, 1, 1, 32'sh0001_0000);
    // keep offering right behind the compute so the long hold-off hits
    gap_calm = 4;
    compute();
    send(CMD_WR_A, 0, 0, 32'sh0000_C000);
    send(CMD_WR_B, 1, 1, -32'sh0002_0000);
    compute();
    // order above the maximum behaves as the maximum
    set_order(15);
    fill_block();
    compute();

    // --- random phases: optional reorder, random writes, fill, compute ---
    while (reqs_sent < RAND_REQS) begin
      if ($urandom_range(1) == 0) begin
        pick = $urandom_range(99);
        if (pick < 60) set_order($urandom_range(1, 4));
        else if (pick < 80) set_order($urandom_range(5, 7));
        else if (pick < 90) set_order(ORD);
        else if (pick < 95) set_order(0);
        else set_order($urandom_range(ORD + 1, 15));
      end
      n_wr = $urandom_range(0, 6);
      repeat (n_wr) begin
        pick = $urandom_range(99);
        lim  = ($urandom_range(99) < 70) ? cur_n - 1 : ORD - 1;
        if (pick < 5) begin
          send(CMD_UNUSED, $urandom_range(7), $urandom_range(7), q16_t'($urandom()));
        end else if (pick < 52) begin
          send(CMD_WR_A, $urandom_range(lim), $urandom_range(lim), rand_q());
        end else begin
          send(CMD_WR_B, $urandom_range(lim), $urandom_range(lim), rand_q());
        end
      end
      fill_block();
      compute();
    end

    // --- wrap up ---
    drain();
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
